@@ rtl/slrg_pkg.sv @@
// Package for the shuffled Lehmer random generator.
// Holds the generator constants, the sequencer state and control types and the modular fold.
// No dependencies.
package slrg_pkg;

   // Default shape of the shuffle table and the number of discarded seeding steps.
   localparam int TABLE_SIZE_DEF   = 32;
   localparam int WARMUP_STEPS_DEF = 8;

   // Generator constants: x' = 16807 * x mod (2^31 - 1).
   localparam int              PROD_W        = 47;
   localparam logic [14:0]     LEH_MULT      = 15'd16807;
   localparam logic [30:0]     LEH_MOD       = 31'h7FFF_FFFF;

   // A fraction at or above this integer rounds past 1 - 1.2e-7 and is capped.
   localparam logic [30:0]     CAP_THRESHOLD = 31'd2147483328;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEED_MUL,
      ST_SEED_FOLD,
      ST_DRAW_DIV,
      ST_DRAW_READ,
      ST_DRAW_FOLD
   } state_type;

   // Control strobes from the sequencer to the datapath.
   typedef struct packed {
      logic accept;
      logic check;
      logic mul_en;
      logic seed_fold;
      logic div_step;
      logic mem_rd;
      logic draw_done;
   } ctrl_type;

   // Reduces a product 16807 * x (x <= 2^31) modulo 2^31 - 1.
   function automatic logic [30:0] lehmer_fold(input logic [PROD_W-1:0] prod);
      logic [31:0] sum1;
      logic [30:0] sum2;
      sum1 = 32'(prod[PROD_W-1:31]) + 32'(prod[30:0]);
      sum2 = sum1[30:0] + 31'(sum1[31]);
      return (sum2 == LEH_MOD) ? 31'd0 : sum2;
   endfunction

endpackage

@@ rtl/shuffled_lehmer_random_generator.sv @@
// Top level of the shuffled Lehmer random generator: sequencer, shared multiply-and-fold
// unit, slot boundary compare and the shuffle table memory.
// Depends on slrg_pkg.
//
// Each request item draws one number from a minimal standard Lehmer generator passed
// through a Bays-Durham shuffle table, and yields exactly one response item. With
// req_tuser high the generator value is first replaced by req_tdata. When that value is
// zero or negative, or the table has never been filled (as after reset), the table is
// seeded first: TABLE_SIZE + WARMUP_STEPS generator steps, each a multiply and a fold state,
// on the one shared multiply-and-fold unit. A plain draw runs through a check state, a state
// that starts the multiply and picks the slot by comparing the last output against the slot
// boundaries, a table read and a fold and write-back, which waits while the output register
// holds a response not yet taken; seeding runs between the check and the draw. The block is
// ready for the next request as soon as the response is loaded, while that response may
// still wait in its output register. The table needs no clearing pass after reset.
module shuffled_lehmer_random_generator #(
   parameter int TABLE_SIZE   = slrg_pkg::TABLE_SIZE_DEF,
   parameter int WARMUP_STEPS = slrg_pkg::WARMUP_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed_value (signed)
   input  logic        req_tuser,   // [0] command: 0 draw, 1 reseed then draw
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [30:0] random_value, [61:31] generator_value, zero pad
   output logic        rsp_tuser    // [0] capped
);

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam int CNT_W  = $clog2(TABLE_SIZE + WARMUP_STEPS);
   localparam logic [31:0]       SLOT_DIV  = 32'(1 + (2147483646 / TABLE_SIZE));
   localparam logic [CNT_W-1:0]  SEED_LAST = CNT_W'(TABLE_SIZE + WARMUP_STEPS - 1);
   localparam logic [ADDR_W-1:0] SLOT_MAX  = ADDR_W'(TABLE_SIZE - 1);

   // Control state.
   slrg_pkg::state_type state_ff, state_in;
   slrg_pkg::ctrl_type  ctrl;
   logic signed [31:0]  lehmer_ff;
   logic [30:0]         last_ff;
   logic                rsp_valid_ff;

   // Datapath registers.
   logic [31:0]                 x_ff;
   logic [slrg_pkg::PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [ADDR_W-1:0]           slot_ff;
   logic [30:0]                 rd_data_ff;
   logic [63:0]                 rsp_data_ff;
   logic                        rsp_user_ff;
   logic [30:0]                 table_ff [TABLE_SIZE];

   // Combinational helpers.
   logic        need_seed;
   logic [31:0] seed_start;
   logic [30:0] fold;
   logic [ADDR_W-1:0] slot_calc;
   logic [ADDR_W-1:0] slot_sat;
   logic        seed_in_table;
   logic        out_free;
   logic        mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;

   assign need_seed  = (lehmer_ff <= 32'sd0) || (last_ff == 31'd0);
   assign seed_start = lehmer_ff[31] ? 32'(-lehmer_ff) : 32'd1;
   assign fold       = slrg_pkg::lehmer_fold(prod_ff);
   assign slot_sat   = (slot_ff > SLOT_MAX) ? SLOT_MAX : slot_ff;
   assign seed_in_table = (32'(cnt_ff) < 32'(TABLE_SIZE));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Slot of the last output: the highest slot boundary that it reaches. The boundaries
   // rise with the slot, so the last one passed wins, and the top slot is never exceeded.
   always_comb begin
      slot_calc = '0;
      for (int k = 1; k < TABLE_SIZE; k++) begin
         if ({1'b0, last_ff} >= (32'(k) * SLOT_DIV)) slot_calc = ADDR_W'(k);
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slrg_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = slrg_pkg::ST_CHECK;
         end
         slrg_pkg::ST_CHECK: begin
            state_in = need_seed ? slrg_pkg::ST_SEED_MUL : slrg_pkg::ST_DRAW_DIV;
         end
         slrg_pkg::ST_SEED_MUL: begin
            state_in = slrg_pkg::ST_SEED_FOLD;
         end
         slrg_pkg::ST_SEED_FOLD: begin
            state_in = (cnt_ff == '0) ? slrg_pkg::ST_DRAW_DIV : slrg_pkg::ST_SEED_MUL;
         end
         slrg_pkg::ST_DRAW_DIV: begin
            state_in = slrg_pkg::ST_DRAW_READ;
         end
         slrg_pkg::ST_DRAW_READ: begin
            state_in = slrg_pkg::ST_DRAW_FOLD;
         end
         slrg_pkg::ST_DRAW_FOLD: begin
            if (out_free) state_in = slrg_pkg::ST_IDLE;
         end
         default: begin
            state_in = slrg_pkg::ST_IDLE;
         end
      endcase
   end

   // Control strobes decoded from the state.
   always_comb begin
      ctrl.accept    = (state_ff == slrg_pkg::ST_IDLE) && req_tvalid;
      ctrl.check     = (state_ff == slrg_pkg::ST_CHECK);
      ctrl.mul_en    = (state_ff == slrg_pkg::ST_SEED_MUL) ||
                       (state_ff == slrg_pkg::ST_DRAW_DIV);
      ctrl.seed_fold = (state_ff == slrg_pkg::ST_SEED_FOLD);
      ctrl.div_step  = (state_ff == slrg_pkg::ST_DRAW_DIV);
      ctrl.mem_rd    = (state_ff == slrg_pkg::ST_DRAW_READ);
      ctrl.draw_done = (state_ff == slrg_pkg::ST_DRAW_FOLD) && out_free;
   end

   // Sequencer, generator value, last output and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slrg_pkg::ST_IDLE;
         lehmer_ff    <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctrl.accept && req_tuser) begin
            lehmer_ff <= req_tdata;
         end else if ((ctrl.seed_fold && (cnt_ff == '0)) || ctrl.draw_done) begin
            lehmer_ff <= {1'b0, fold};
         end
         if (ctrl.seed_fold && (cnt_ff == '0)) begin
            last_ff <= fold;
         end else if (ctrl.draw_done) begin
            last_ff <= rd_data_ff;
         end
         if (ctrl.draw_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Shared multiplier, seeding counter and slot register.
   always_ff @(posedge clock) begin
      if (ctrl.check) begin
         if (need_seed) begin
            x_ff   <= seed_start;
            cnt_ff <= SEED_LAST;
         end else begin
            x_ff <= 32'(lehmer_ff);
         end
      end
      if (ctrl.mul_en) begin
         prod_ff <= slrg_pkg::PROD_W'(x_ff) * slrg_pkg::PROD_W'(slrg_pkg::LEH_MULT);
      end
      if (ctrl.seed_fold) begin
         x_ff   <= {1'b0, fold};
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (ctrl.div_step) begin
         slot_ff <= slot_calc;
      end
   end

   // Shuffle table: one write port, one registered read port.
   assign mem_wr_en   = (ctrl.seed_fold && seed_in_table) || ctrl.draw_done;
   assign mem_wr_addr = ctrl.seed_fold ? cnt_ff[ADDR_W-1:0] : slot_sat;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         table_ff[mem_wr_addr] <= fold;
      end
      if (ctrl.mem_rd) begin
         rd_data_ff <= table_ff[slot_sat];
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (ctrl.draw_done) begin
         rsp_data_ff <= {2'b00, fold, rd_data_ff};
         rsp_user_ff <= (rd_data_ff >= slrg_pkg::CAP_THRESHOLD);
      end
   end

   assign req_tready = (state_ff == slrg_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // An accepted item always goes to the seeding check next.
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == slrg_pkg::ST_CHECK))
      else $error("accepted item did not reach the seeding check");

   // The selected slot never leaves the table.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slrg_pkg::ST_DRAW_READ) |-> (32'(slot_ff) < 32'(TABLE_SIZE)))
      else $error("slot index beyond the shuffle table");

   // The seeding counter stays within the seeding run.
   a_seed_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slrg_pkg::ST_SEED_MUL) |->
      (32'(cnt_ff) <= 32'(TABLE_SIZE + WARMUP_STEPS - 1)))
      else $error("seeding counter out of range");

   // A finished draw shows up as a valid response and frees the request side.
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      ctrl.draw_done |=> (rsp_tvalid && req_tready))
      else $error("finished draw did not load the response");

endmodule
